[rtl/core/mspagc_pkg.sv]
`default_nettype none

package mspagc_pkg;

  // Default depth of one feed chunk, in frames
  localparam int MAX_CHUNK_DEF = 1024;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BITS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_VOLUME        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_FACTOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESSING_ENABLED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SAMPLES      = 3'd4;

  localparam logic [3:0]  GAIN_BITS_RST        = 4'd0;
  localparam logic        AUTO_VOLUME_RST      = 1'b0;
  localparam logic [15:0] SMOOTHING_FACTOR_RST = 16'd655;
  localparam logic        PROCESSING_RST       = 1'b0;
  localparam logic [10:0] CHUNK_SAMPLES_RST    = 11'd512;

  // Peak tracking arithmetic, peak in Q24.16 and gain in Q0.16
  localparam int MAG_W  = 31;
  localparam int PEAK_W = 40;
  localparam int FRAC_W = 16;
  localparam int QUOT_W = 16;
  localparam int PROD_W = PEAK_W + FRAC_W;

  localparam logic [PEAK_W-1:0] PEAK_ONE = 40'h00_0001_0000;
  localparam logic [PEAK_W-1:0] PEAK_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [PEAK_W-1:0] PEAK_LIM = 40'h00_7FFF_0000;

  localparam logic signed [15:0] I16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] I16_MIN = -16'sh8000;

  typedef struct packed {
    logic signed [31:0] mic_word;
    logic signed [15:0] ref_sample;
    logic               ref_present;
  } mic_in_t;

  typedef struct packed {
    logic signed [15:0] mic_sample;
    logic signed [15:0] ref_out;
    logic               chunk_last;
  } mic_out_t;

  // One classified request as it waits for the back
  typedef struct packed {
    logic signed [31:0] raw;
    logic               agc;
    logic signed [15:0] ref_out;
    logic               chunk_last;
  } agc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_UPD,
    ST_CHK,
    ST_DIV,
    ST_MULG,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/mic_sample_peak_agc_core.sv]
`default_nettype none

// Microphone sample scaler with peak-tracking gain control.
// The sample channel (sample_valid, sample_stall, sample) takes one raw I2S slot
// with its paired reference sample; a request is taken when valid is high and
// stall is low. The result channel (result_valid, result_stall, result) gives
// exactly one scaled, saturated sample per request, in order, with the reference
// and the end-of-chunk flag.
// A front stage classifies each request and counts chunk entries, a two-entry
// queue holds it, and a back engine applies the gain and owns the output register.
// With gain control on, the back engine also tracks the peak and, when it lies above
// 32767, forms the gain by bit-serial division of 32767 by the peak; it takes a
// new request from the queue only once it is through with the last one.
// The user must write registers on the cfg port only while the block is idle;
// the block does not enforce this. Reset restores every cfg register to its
// default, sets the peak to 1.0, clears the chunk position and empties the
// queue. While result_stall is high the result holds; the queue still takes
// requests until it is full, and then sample_stall rises.
module mic_sample_peak_agc_core #(
  parameter int MAX_CHUNK = mspagc_pkg::MAX_CHUNK_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  mspagc_pkg::mic_in_t                sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mspagc_pkg::mic_out_t               result,
  input  logic                               cfg_wr_en,
  input  logic [mspagc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mspagc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mspagc_pkg::*;

  logic [3:0]  gain_bits;
  logic        auto_volume;
  logic [15:0] smoothing_factor;
  logic        processing_enabled;
  logic [10:0] chunk_samples;

  logic        push;
  logic        pop;
  agc_item_t   wr_item;
  agc_item_t   rd_item;
  q_status_t   qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_bits          <= GAIN_BITS_RST;
      auto_volume        <= AUTO_VOLUME_RST;
      smoothing_factor   <= SMOOTHING_FACTOR_RST;
      processing_enabled <= PROCESSING_RST;
      chunk_samples      <= CHUNK_SAMPLES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN_BITS:          gain_bits          <= cfg_data[3:0];
        CFG_AUTO_VOLUME:        auto_volume        <= cfg_data[0];
        CFG_SMOOTHING_FACTOR:   smoothing_factor   <= cfg_data;
        CFG_PROCESSING_ENABLED: processing_enabled <= cfg_data[0];
        CFG_CHUNK_SAMPLES:      chunk_samples      <= cfg_data[10:0];
        default: begin
          gain_bits <= gain_bits;
        end
      endcase
    end
  end

  mspagc_front #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .sample_stall       (sample_stall),
    .sample             (sample),
    .gain_bits          (gain_bits),
    .auto_volume        (auto_volume),
    .processing_enabled (processing_enabled),
    .chunk_samples      (chunk_samples),
    .qstat              (qstat),
    .push               (push),
    .entry              (wr_item)
  );

  mspagc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  mspagc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .qstat            (qstat),
    .item             (rd_item),
    .pop              (pop),
    .smoothing_factor (smoothing_factor),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result)
  );

endmodule

`default_nettype wire

[rtl/core/mspagc_front.sv]
`default_nettype none

module mspagc_front #(
  parameter int MAX_CHUNK = mspagc_pkg::MAX_CHUNK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  mspagc_pkg::mic_in_t   sample,
  input  logic [3:0]            gain_bits,
  input  logic                  auto_volume,
  input  logic                  processing_enabled,
  input  logic [10:0]           chunk_samples,
  input  mspagc_pkg::q_status_t qstat,
  output logic                  push,
  output mspagc_pkg::agc_item_t entry
);
  import mspagc_pkg::*;

  localparam int PW = $clog2(2 * MAX_CHUNK + 2);

  logic [PW-1:0]      chunk_pos;
  logic [PW-1:0]      chunk_pos_next;
  logic [PW-1:0]      pos_sum;
  logic [PW-1:0]      limit;
  logic               last;
  logic signed [31:0] shifted;
  logic [4:0]         shamt;

  assign sample_stall = qstat.full;
  assign push         = sample_valid && !qstat.full;

  // Drop the unused top bit of the slot, then keep gain_bits more bits of magnitude.
  assign shifted = {sample.mic_word[30:0], 1'b0};
  assign shamt   = 5'd16 - {1'b0, gain_bits};

  always_comb begin
    if (chunk_samples == 11'd0) begin
      limit = PW'(2);
    end else if (chunk_samples > MAX_CHUNK) begin
      limit = PW'(2 * MAX_CHUNK);
    end else begin
      limit = PW'({chunk_samples, 1'b0});
    end
  end

  assign pos_sum = chunk_pos + (processing_enabled ? PW'(2) : PW'(1));
  assign last    = (pos_sum >= limit);

  always_comb begin
    chunk_pos_next = chunk_pos;
    if (push) begin
      chunk_pos_next = last ? '0 : pos_sum;
    end
  end

  always_comb begin
    entry.raw        = shifted >>> shamt;
    entry.agc        = auto_volume;
    entry.ref_out    = (processing_enabled && sample.ref_present) ? sample.ref_sample : '0;
    entry.chunk_last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_pos <= '0;
    end else begin
      chunk_pos <= chunk_pos_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mspagc_queue.sv]
`default_nettype none

module mspagc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mspagc_pkg::agc_item_t wr_item,
  input  logic                  pop,
  output mspagc_pkg::agc_item_t rd_item,
  output mspagc_pkg::q_status_t qstat
);
  import mspagc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  agc_item_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_item     = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

[rtl/core/mspagc_back.sv]
`default_nettype none

module mspagc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mspagc_pkg::q_status_t qstat,
  input  mspagc_pkg::agc_item_t item,
  output logic                  pop,
  input  logic [15:0]           smoothing_factor,
  output logic                  result_valid,
  input  logic                  result_stall,
  output mspagc_pkg::mic_out_t  result
);
  import mspagc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  back_state_t         state;
  back_state_t         state_next;
  logic [PEAK_W-1:0]   peak_level;
  logic [PEAK_W-1:0]   peak_level_next;
  logic                out_load;
  logic                out_free;

  logic [MAG_W-1:0]    mag;
  logic                neg;
  logic signed [31:0]  res;
  logic signed [15:0]  ref_out;
  logic                chunk_last;
  logic [PROD_W-1:0]   prod;
  logic [PEAK_W-1:0]   rem;
  logic [QUOT_W-1:0]   quot;
  logic [CNT_W-1:0]    cnt;

  logic [31:0]         item_abs;
  logic [PEAK_W-1:0]   a_sat;
  logic                rise;
  logic [PEAK_W-1:0]   diff;
  logic [PROD_W-1:0]   decayed;
  logic [PEAK_W:0]     rem_sh;
  logic                fits;
  logic [MAG_W+QUOT_W-1:0] scaled;
  logic signed [15:0]  sat;

  assign out_free = !result_valid || !result_stall;

  assign item_abs = item.raw[31] ? 32'(-item.raw) : 32'(item.raw);

  // New absolute sample in Q24.16, pinned at the largest peak.
  assign a_sat   = (|mag[MAG_W-1:24]) ? PEAK_MAX : {mag[23:0], 16'h0000};
  assign rise    = (a_sat > peak_level);
  assign diff    = peak_level - a_sat;
  assign decayed = {peak_level, 16'h0000} - prod;
  assign rem_sh  = {rem, 1'b0};
  assign fits    = (rem_sh >= {1'b0, peak_level});
  assign scaled  = mag * quot;

  always_comb begin
    if (res > 32'sd32767) begin
      sat = I16_MAX;
    end else if (res < -32'sd32768) begin
      sat = I16_MIN;
    end else begin
      sat = res[15:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_next = item.agc ? ST_MULT : ST_DONE;
        end
      end
      ST_MULT: state_next = rise ? ST_CHK : ST_UPD;
      ST_UPD:  state_next = ST_CHK;
      ST_CHK:  state_next = (peak_level <= PEAK_LIM) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          state_next = ST_MULG;
        end
      end
      ST_MULG: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: pop      = !qstat.empty;
      ST_DONE: out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    peak_level_next = peak_level;
    if (state == ST_MULT && rise) begin
      peak_level_next = a_sat;
    end else if (state == ST_UPD) begin
      peak_level_next = (decayed[PROD_W-1:FRAC_W] < PEAK_ONE) ? PEAK_ONE
                                                               : decayed[PROD_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      peak_level   <= PEAK_ONE;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      peak_level <= peak_level_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mag        <= item_abs[MAG_W-1:0];
      neg        <= item.raw[31];
      res        <= item.raw;
      ref_out    <= item.ref_out;
      chunk_last <= item.chunk_last;
    end
    if (state == ST_MULT) begin
      prod <= diff * smoothing_factor;
    end
    if (state == ST_CHK) begin
      rem  <= PEAK_LIM;
      quot <= '0;
      cnt  <= '0;
    end
    // Long division of 32767 in Q24.16 by the peak, one quotient bit a cycle.
    if (state == ST_DIV) begin
      rem  <= fits ? PEAK_W'(rem_sh - {1'b0, peak_level}) : rem_sh[PEAK_W-1:0];
      quot <= {quot[QUOT_W-2:0], fits};
      cnt  <= cnt + CNT_W'(1);
    end
    if (state == ST_MULG) begin
      res <= neg ? -$signed({1'b0, scaled[MAG_W+QUOT_W-1:QUOT_W]})
                 : $signed({1'b0, scaled[MAG_W+QUOT_W-1:QUOT_W]});
    end
    if (out_load) begin
      result.mic_sample <= sat;
      result.ref_out    <= ref_out;
      result.chunk_last <= chunk_last;
    end
  end

  a_peak_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |-> (peak_level >= PEAK_ONE))
    else $error("peak below unity before gain check");
  a_mulg_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULG) |-> ($past(state) == ST_DIV))
    else $error("gain multiply without a finished division");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result_valid)
    else $error("result register loaded but not valid");

endmodule

`default_nettype wire
